// ===== rtl/ese_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ese_pkg
// Shared constants and controller/datapath interface types of the exchange
// sort engine.
// ---------------------------------------------------------------------------
package ese_pkg;

  // storage and field sizes
  localparam int unsigned DEPTH      = 64;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned IDX_BITS   = $clog2(DEPTH);
  localparam int unsigned CNT_BITS   = $clog2(DEPTH + 1);
  localparam int unsigned TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

  // case-fold range (upper-case letter codes) and fold offset
  localparam logic signed [VALUE_BITS-1:0] FOLD_LO  = VALUE_BITS'(65);
  localparam logic signed [VALUE_BITS-1:0] FOLD_HI  = VALUE_BITS'(90);
  localparam logic signed [VALUE_BITS-1:0] FOLD_OFS = VALUE_BITS'(32);

  // source of the store write data
  typedef enum logic {
    WSRC_INPUT = 1'b0,
    WSRC_CUR   = 1'b1
  } wsrc_e;

  // commands from controller to datapath
  typedef struct packed {
    logic                ram_we;
    logic [IDX_BITS-1:0] ram_waddr;
    wsrc_e               ram_wsrc;
    logic                ram_re;
    logic [IDX_BITS-1:0] ram_raddr;
    logic                cur_load;
    logic                cmp_en;
    logic                out_load;
    logic                out_last;
    logic                out_ovf;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic swap;
    logic out_free;
  } dp_status_t;

  // comparison key: upper-case codes folded when enabled
  function automatic logic signed [VALUE_BITS-1:0] sort_key(
    input logic signed [VALUE_BITS-1:0] v,
    input logic                         fold
  );
    logic signed [VALUE_BITS-1:0] k;
    k = v;
    if (fold && (v >= FOLD_LO) && (v <= FOLD_HI)) begin
      k = v + FOLD_OFS;
    end
    return k;
  endfunction

endpackage

// ===== rtl/ese_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ese_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ---------------------------------------------------------------------------
module ese_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ese_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ese_datapath
// Element store, held element register, key comparator, case-fold register
// and the output register of the exchange sort engine.
// ---------------------------------------------------------------------------
module ese_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ese_pkg::ctrl_cmd_t                cmd_i,
  output ese_pkg::dp_status_t               status_o,
  input  logic [ese_pkg::VALUE_BITS-1:0]    in_value_i,
  input  logic                              cfg_we_i,
  input  logic                              cfg_fold_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [ese_pkg::VALUE_BITS-1:0]    out_value_o,
  output logic                              out_last_o,
  output logic                              out_ovf_o
);

  import ese_pkg::*;

  logic                  fold_q;
  logic [VALUE_BITS-1:0] cur_q, cur_d;
  logic [VALUE_BITS-1:0] rdata;
  logic [VALUE_BITS-1:0] wdata;
  logic                  swap;
  logic                  out_valid_q;
  logic [VALUE_BITS-1:0] out_value_q;
  logic                  out_last_q;
  logic                  out_ovf_q;

  // case-fold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= 1'b0;
    end else if (cfg_we_i) begin
      fold_q <= cfg_fold_i;
    end
  end

  // store write data select
  always_comb begin
    unique case (cmd_i.ram_wsrc)
      WSRC_INPUT: wdata = in_value_i;
      WSRC_CUR:   wdata = cur_q;
      default:    wdata = in_value_i;
    endcase
  end

  // element store
  ese_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (cmd_i.ram_waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.ram_re),
    .raddr_i (cmd_i.ram_raddr),
    .rdata_o (rdata)
  );

  // held element greater than the element read: exchange
  assign swap = sort_key($signed(cur_q), fold_q) > sort_key($signed(rdata), fold_q);

  // held element register
  always_comb begin
    cur_d = cur_q;
    if (cmd_i.cur_load || (cmd_i.cmp_en && swap)) begin
      cur_d = rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= rdata;
      out_last_q  <= cmd_i.out_last;
      out_ovf_q   <= cmd_i.out_ovf;
    end
  end

  assign status_o.swap     = swap;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

// ===== rtl/ese_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ese_ctrl
// Sequencer of the exchange sort engine: load, sort passes over the store
// and emission of the sorted run.
// ---------------------------------------------------------------------------
module ese_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  output ese_pkg::ctrl_cmd_t   cmd_o,
  input  ese_pkg::dp_status_t  status_i
);

  import ese_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_LDI  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_WRI  = 3'd3;
  localparam logic [2:0] S_ERD  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                drop_q, drop_d;
  logic [IDX_BITS-1:0] i_q, i_d;
  logic [IDX_BITS-1:0] j_q, j_d;
  logic [CNT_BITS-1:0] cnt_inc;
  logic [CNT_BITS-1:0] i_next;
  logic [CNT_BITS-1:0] j_next;
  logic [CNT_BITS-1:0] i_next2;
  logic                accept;

  assign in_ready_o = (state_q == S_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_inc    = cnt_q + CNT_BITS'(1);
  assign i_next     = CNT_BITS'(i_q) + CNT_BITS'(1);
  assign i_next2    = CNT_BITS'(i_q) + CNT_BITS'(2);
  assign j_next     = CNT_BITS'(j_q) + CNT_BITS'(1);

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    drop_d  = drop_q;
    i_d     = i_q;
    j_d     = j_q;
    cmd_o   = '0;
    cmd_o.ram_wsrc = WSRC_INPUT;

    unique case (state_q)
      // collect elements until one is marked last
      S_LOAD: begin
        if (accept) begin
          if (cnt_q < CNT_BITS'(DEPTH)) begin
            cmd_o.ram_we    = 1'b1;
            cmd_o.ram_waddr = cnt_q[IDX_BITS-1:0];
            cnt_d           = cnt_inc;
          end else begin
            drop_d = 1'b1;
          end
          if (in_last_i) begin
            i_d = '0;
            if (cnt_d > CNT_BITS'(1)) begin
              // first pass: fetch entry zero
              cmd_o.ram_re    = 1'b1;
              cmd_o.ram_raddr = '0;
              state_d         = S_LDI;
            end else begin
              state_d = S_ERD;
            end
          end
        end
      end
      // take entry i as held element, fetch the first later entry
      S_LDI: begin
        cmd_o.cur_load  = 1'b1;
        cmd_o.ram_re    = 1'b1;
        cmd_o.ram_raddr = i_next[IDX_BITS-1:0];
        j_d             = i_next[IDX_BITS-1:0];
        state_d         = S_CMP;
      end
      // compare held element with entry j, exchange when greater
      S_CMP: begin
        cmd_o.cmp_en    = 1'b1;
        cmd_o.ram_we    = status_i.swap;
        cmd_o.ram_waddr = j_q;
        cmd_o.ram_wsrc  = WSRC_CUR;
        if (j_next < cnt_q) begin
          cmd_o.ram_re    = 1'b1;
          cmd_o.ram_raddr = j_next[IDX_BITS-1:0];
          j_d             = j_next[IDX_BITS-1:0];
        end else begin
          state_d = S_WRI;
        end
      end
      // put the pass minimum back at i, start the next pass or go on to emission
      S_WRI: begin
        cmd_o.ram_we    = 1'b1;
        cmd_o.ram_waddr = i_q;
        cmd_o.ram_wsrc  = WSRC_CUR;
        if (i_next2 < cnt_q) begin
          cmd_o.ram_re    = 1'b1;
          cmd_o.ram_raddr = i_next[IDX_BITS-1:0];
          i_d             = i_next[IDX_BITS-1:0];
          state_d         = S_LDI;
        end else begin
          i_d     = '0;
          state_d = S_ERD;
        end
      end
      // fetch the first sorted entry
      S_ERD: begin
        cmd_o.ram_re    = 1'b1;
        cmd_o.ram_raddr = '0;
        i_d             = '0;
        state_d         = S_EMIT;
      end
      // hand sorted entries to the output register
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ovf  = drop_q;
          if (i_next == cnt_q) begin
            cmd_o.out_last = 1'b1;
            cnt_d          = '0;
            drop_d         = 1'b0;
            state_d        = S_LOAD;
          end else begin
            cmd_o.ram_re    = 1'b1;
            cmd_o.ram_raddr = i_next[IDX_BITS-1:0];
            i_d             = i_next[IDX_BITS-1:0];
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

endmodule

// ===== rtl/exchange_sort_engine.sv =====
`timescale 1ns / 1ps
// Sorting runs after the last transaction of a set: one compare per cycle on
// the store's single read port, with a load (S_LDI) and a write-back (S_WRI)
// step per pass, then a store read and an output load before the first result.
// Throughput: one input per cycle while loading, one result per cycle out
// while m_axis_tready is held; no new set is taken until the run is out.
// Reset: asynchronous, active low; clears count, overflow flag and case fold.
// ---------------------------------------------------------------------------
// exchange_sort_engine
// Collects signed values, sorts each set ascending by exchange sort and
// streams the sorted run out with a last marker and an overflow flag.
// ---------------------------------------------------------------------------
module exchange_sort_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write: bit 0 is case_fold
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ese_pkg::TDATA_BITS-1:0]   s_axis_tdata,  // value
  input  logic                             s_axis_tlast,  // last
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ese_pkg::TDATA_BITS-1:0]   m_axis_tdata,  // sorted_value
  output logic                             m_axis_tlast,  // end_of_run
  output logic                             m_axis_tuser   // overflow
);

  import ese_pkg::*;

  ctrl_cmd_t             cmd;
  dp_status_t            status;
  logic [VALUE_BITS-1:0] out_value;

  assign cfg_ready_o = 1'b1;

  // sequencer
  ese_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // store, comparator and output register
  ese_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_value_i  (s_axis_tdata[VALUE_BITS-1:0]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_fold_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (m_axis_tuser)
  );

  // zero fill up to whole bytes
  assign m_axis_tdata = TDATA_BITS'(out_value);

endmodule
